// ===== rtl/tfb_pkg.sv =====
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types, constants and the CRC-16/ARC byte update for the torque
// frame builder.
// ----------------------------------------------------------------------------
package tfb_pkg;

    localparam int JOINT_COUNT_DEF = 12;
    localparam int JOINT_MIN       = 2;
    localparam int JOINT_MAX       = 84;
    localparam int JOINT_W         = 7;
    localparam int CODE_W          = 16;
    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 8'd1;

    localparam logic [BYTE_W-1:0] COMMAND_RESET = 8'h03;
    localparam logic [BYTE_W-1:0] LENGTH_RESET  = 8'h28;
    localparam logic [15:0]       CRC_POLY      = 16'hA001;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [JOINT_W-1:0] id;
        logic [BYTE_W-1:0]  cmd;
        logic [BYTE_W-1:0]  len;
        logic               first;
        logic               last;
    } tfb_entry_t;

    typedef enum logic [2:0] {
        STEP_START,
        STEP_CMD,
        STEP_LEN,
        STEP_ID,
        STEP_HI,
        STEP_LO,
        STEP_CRC_LO,
        STEP_CRC_HI
    } tfb_step_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [BYTE_W-1:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < BYTE_W; b++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== rtl/tfb_if.sv =====
// ----------------------------------------------------------------------------
// tfb_if
// Channel interfaces: torque requests in, frame bytes out, register writes.
// ----------------------------------------------------------------------------
interface tfb_in_if;
    logic                        valid;
    logic                        ready;
    logic [tfb_pkg::CODE_W-1:0]  torque_code;
    modport source (output valid, output torque_code, input ready);
    modport sink   (input valid, input torque_code, output ready);
endinterface

interface tfb_out_if;
    logic                        valid;
    logic                        ready;
    logic [tfb_pkg::BYTE_W-1:0]  out_byte;
    logic                        last_of_item;
    logic                        last_of_frame;
    modport source (output valid, output out_byte, output last_of_item,
                    output last_of_frame, input ready);
    modport sink   (input valid, input out_byte, input last_of_item,
                    input last_of_frame, output ready);
endinterface

interface tfb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tfb_pkg::CFG_IDX_W-1:0] index;
    logic [tfb_pkg::BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tfb_front.sv =====
// ----------------------------------------------------------------------------
// tfb_front
// Accepts torque requests, tracks the joint position in the frame and
// holds the header registers; pushes one classified entry per request.
// ----------------------------------------------------------------------------
module tfb_front #(
    parameter int JOINT_COUNT = tfb_pkg::JOINT_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    tfb_in_if.sink              torque,
    tfb_cfg_if.sink             cfg,
    input  logic                q_full,
    output logic                q_push,
    output tfb_pkg::tfb_entry_t q_entry
);

    localparam int EFF_JOINTS = (JOINT_COUNT < tfb_pkg::JOINT_MIN) ? tfb_pkg::JOINT_MIN :
                                (JOINT_COUNT > tfb_pkg::JOINT_MAX) ? tfb_pkg::JOINT_MAX :
                                JOINT_COUNT;
    localparam logic [tfb_pkg::JOINT_W-1:0] LAST_ID = tfb_pkg::JOINT_W'(EFF_JOINTS);

    logic [tfb_pkg::JOINT_W-1:0] joint_idx_reg, joint_idx_next;
    logic [tfb_pkg::BYTE_W-1:0]  command_reg, command_next;
    logic [tfb_pkg::BYTE_W-1:0]  length_reg, length_next;
    logic [tfb_pkg::JOINT_W-1:0] id;
    logic                        last;

    assign torque.ready = !q_full;
    assign cfg.ready    = 1'b1;
    assign q_push       = torque.valid && torque.ready;

    assign id   = joint_idx_reg + 1'b1;
    assign last = (id == LAST_ID);

    always_comb
    begin
        q_entry.code  = torque.torque_code;
        q_entry.id    = id;
        q_entry.cmd   = command_reg;
        q_entry.len   = length_reg;
        q_entry.first = (joint_idx_reg == '0);
        q_entry.last  = last;
    end

    always_comb
    begin
        joint_idx_next = joint_idx_reg;
        if (q_push)
            joint_idx_next = last ? '0 : id;
    end

    always_comb
    begin
        command_next = command_reg;
        length_next  = length_reg;
        if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == tfb_pkg::REG_COMMAND)
                command_next = cfg.data;
            else if (cfg.index == tfb_pkg::REG_LENGTH)
                length_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_idx_reg <= '0;
            command_reg   <= tfb_pkg::COMMAND_RESET;
            length_reg    <= tfb_pkg::LENGTH_RESET;
        end
        else
        begin
            joint_idx_reg <= joint_idx_next;
            command_reg   <= command_next;
            length_reg    <= length_next;
        end
    end

endmodule

// ===== rtl/tfb_queue.sv =====
// ----------------------------------------------------------------------------
// tfb_queue
// Two-entry queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module tfb_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tfb_pkg::tfb_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output tfb_pkg::tfb_entry_t head
);

    localparam int PTR_W = $clog2(tfb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tfb_pkg::QUEUE_DEPTH + 1);

    tfb_pkg::tfb_entry_t mem [tfb_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(tfb_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tfb_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tfb_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/tfb_back.sv =====
// ----------------------------------------------------------------------------
// tfb_back
// Byte sequencer: walks each queued entry through its frame bytes, keeps
// the running CRC and drives the registered output channel.
// ----------------------------------------------------------------------------
module tfb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  tfb_pkg::tfb_entry_t q_head,
    output logic                q_pop,
    tfb_out_if.source           frame
);

    tfb_pkg::tfb_step_t          step_reg, step_next, cur_step;
    logic [15:0]                 crc_reg, crc_next;
    logic                        valid_reg, valid_next;
    logic [tfb_pkg::BYTE_W-1:0]  byte_reg, byte_next;
    logic                        item_end_reg, item_end_next;
    logic                        frame_end_reg, frame_end_next;
    logic                        advance;

    assign advance = !q_empty && (!valid_reg || frame.ready);

    assign frame.valid         = valid_reg;
    assign frame.out_byte      = byte_reg;
    assign frame.last_of_item  = item_end_reg;
    assign frame.last_of_frame = frame_end_reg;

    always_comb
    begin
        cur_step = step_reg;
        if (step_reg == tfb_pkg::STEP_START)
            cur_step = q_head.first ? tfb_pkg::STEP_CMD : tfb_pkg::STEP_ID;
    end

    always_comb
    begin
        step_next      = step_reg;
        crc_next       = crc_reg;
        valid_next     = valid_reg && !frame.ready;
        byte_next      = byte_reg;
        item_end_next  = item_end_reg;
        frame_end_next = frame_end_reg;
        q_pop          = 1'b0;
        if (advance)
        begin
            valid_next     = 1'b1;
            item_end_next  = 1'b0;
            frame_end_next = 1'b0;
            unique case (cur_step)
                tfb_pkg::STEP_CMD:
                begin
                    byte_next = q_head.cmd;
                    crc_next  = tfb_pkg::crc_update(16'h0000, q_head.cmd);
                    step_next = tfb_pkg::STEP_LEN;
                end
                tfb_pkg::STEP_LEN:
                begin
                    byte_next = q_head.len;
                    crc_next  = tfb_pkg::crc_update(crc_reg, q_head.len);
                    step_next = tfb_pkg::STEP_ID;
                end
                tfb_pkg::STEP_ID:
                begin
                    byte_next = {1'b0, q_head.id};
                    crc_next  = tfb_pkg::crc_update(crc_reg, {1'b0, q_head.id});
                    step_next = tfb_pkg::STEP_HI;
                end
                tfb_pkg::STEP_HI:
                begin
                    byte_next = q_head.code[15:8];
                    crc_next  = tfb_pkg::crc_update(crc_reg, q_head.code[15:8]);
                    step_next = tfb_pkg::STEP_LO;
                end
                tfb_pkg::STEP_LO:
                begin
                    byte_next = q_head.code[7:0];
                    crc_next  = tfb_pkg::crc_update(crc_reg, q_head.code[7:0]);
                    if (q_head.last)
                        step_next = tfb_pkg::STEP_CRC_LO;
                    else
                    begin
                        item_end_next = 1'b1;
                        step_next     = tfb_pkg::STEP_START;
                        q_pop         = 1'b1;
                    end
                end
                tfb_pkg::STEP_CRC_LO:
                begin
                    byte_next = crc_reg[7:0];
                    step_next = tfb_pkg::STEP_CRC_HI;
                end
                tfb_pkg::STEP_CRC_HI:
                begin
                    byte_next      = crc_reg[15:8];
                    crc_next       = 16'h0000;
                    item_end_next  = 1'b1;
                    frame_end_next = 1'b1;
                    step_next      = tfb_pkg::STEP_START;
                    q_pop          = 1'b1;
                end
                tfb_pkg::STEP_START:
                begin
                    // resolved to CMD or ID above
                    step_next = tfb_pkg::STEP_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= tfb_pkg::STEP_START;
            crc_reg   <= 16'h0000;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        item_end_reg  <= item_end_next;
        frame_end_reg <= frame_end_next;
    end

endmodule

// ===== rtl/torque_frame_builder_crc16.sv =====
// ----------------------------------------------------------------------------
// torque_frame_builder_crc16
// Builds torque command frames with a CRC-16/ARC trailer.
// ----------------------------------------------------------------------------
// Each torque request yields three frame bytes (joint id, code high, code
// low); the first joint of a frame adds the command and length header bytes
// and the last joint adds the CRC low and high bytes. Bytes leave one per
// cycle through a single output register while the output is ready and an
// entry is queued. A two-entry queue lets new requests in while earlier
// bytes are still being sent. Register writes take effect at once and are
// meant for when the block is idle.
module torque_frame_builder_crc16 #(
    parameter int JOINT_COUNT = tfb_pkg::JOINT_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tfb_in_if.sink     torque,
    tfb_out_if.source  frame,
    tfb_cfg_if.sink    cfg
);

    tfb_pkg::tfb_entry_t push_entry;
    tfb_pkg::tfb_entry_t head;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;

    tfb_front #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .torque  (torque),
        .cfg     (cfg),
        .q_full  (full),
        .q_push  (push),
        .q_entry (push_entry)
    );

    tfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .head       (head)
    );

    tfb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (empty),
        .q_head  (head),
        .q_pop   (pop),
        .frame   (frame)
    );

endmodule

// ===== rtl/tfb_checker.sv =====
// ----------------------------------------------------------------------------
// tfb_checker
// Port-level checks for the torque frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module tfb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [tfb_pkg::BYTE_W-1:0] out_byte,
    input logic                       last_of_item,
    input logic                       last_of_frame
);

    logic [3:0] pending_reg, pending_next;
    logic       in_take;
    logic       item_done;

    assign in_take   = in_valid && in_ready;
    assign item_done = out_valid && out_ready && last_of_item;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_take && !item_done)
            pending_next = pending_reg + 1'b1;
        else if (item_done && !in_take)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output request dropped or changed while stalled");

    a_frame_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_frame |-> last_of_item)
        else $error("frame end without item end");

    a_no_stray_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("output byte with no request in flight");

    a_item_end_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 4'd0 |-> !(out_valid && last_of_item))
        else $error("item end with no request in flight");

endmodule

bind torque_frame_builder_crc16 tfb_checker u_tfb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (torque.valid),
    .in_ready      (torque.ready),
    .out_valid     (frame.valid),
    .out_ready     (frame.ready),
    .out_byte      (frame.out_byte),
    .last_of_item  (frame.last_of_item),
    .last_of_frame (frame.last_of_frame)
);
